// ===== rtl/bsme_pkg.sv =====
`default_nettype none

package bsme_pkg;

  localparam int DEPTH_W = 12;
  localparam int QDEPTH  = 2;

  localparam logic [7:0] OPC_HALT  = 8'h00;
  localparam logic [7:0] OPC_PUSH  = 8'h01;
  localparam logic [7:0] OPC_POP   = 8'h02;
  localparam logic [7:0] OPC_ADD   = 8'h03;
  localparam logic [7:0] OPC_SUM   = 8'h04;
  localparam logic [7:0] OPC_PRIM  = 8'h05;
  localparam logic [7:0] PRIM_PRINT = 8'hFF;

  typedef enum logic [2:0] {
    OP_HALT,
    OP_PUSH,
    OP_POP,
    OP_ADD,
    OP_SUM,
    OP_PRINT,
    OP_BAD_PRIM,
    OP_BAD_OPC
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_HALTED    = 3'd1,
    ST_BAD_OPC   = 3'd2,
    ST_BAD_PRIM  = 3'd3,
    ST_BAD_ARITY = 3'd4,
    ST_UNDERFLOW = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] operand;
  } instr_t;

  typedef struct packed {
    status_e              status;
    logic                 printed;
    logic [7:0]           print_value;
    logic [DEPTH_W-1:0]   stack_depth;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bsme_if.sv =====
`default_nettype none

interface bsme_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface bsme_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic                         printed;
  logic [7:0]                   print_value;
  logic [bsme_pkg::DEPTH_W-1:0] stack_depth;

  modport source (output valid, output status, output printed, output print_value,
                  output stack_depth, input ready);
  modport sink   (input valid, input status, input printed, input print_value,
                  input stack_depth, output ready);
endinterface

`default_nettype wire

// ===== rtl/byte_stack_machine_executor.sv =====
// Byte-code stack machine.
// in_i  : one beat = opcode and operand byte of one instruction.
// out_o : one beat per instruction = status, print flag, printed value and
//         stack depth after the instruction.
// Both channels are valid/ready; a beat moves when both are high.
// Instructions are decoded into a two-deep queue, so the input keeps taking
// beats while the executor works or waits on the output register.
// In the executor, halt, push, pop and every instruction after a stop are
// answered from the idle state; add and print read the top entry and then
// the next one, and a counted sum reads its length, then walks the entries.
// An instruction that ends in an error is answered at once, or once the top
// entry is read when only that shows the error. The stack memory has a
// single read port, which the sum walk reads once per entry.
// An input beat passes the queue and the output register on its way out.
// Reset empties the stack and the queue and clears the stopped flag; no
// clearing pass is needed. After a halt or an error every further beat is
// answered with the halted status and the stack is left untouched.
// A stalled receiver holds the result; the executor waits, and the input
// stalls once the queue is full.
`default_nettype none

module byte_stack_machine_executor #(
  parameter int STACK_DEPTH = 2048
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  bsme_in_if.sink     in_i,
  bsme_out_if.source  out_o
);

  logic             push_valid, push_ready;
  bsme_pkg::instr_t push_data;
  logic             pop_valid, pop_ready;
  bsme_pkg::instr_t pop_data;

  bsme_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  bsme_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  bsme_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bsme_front.sv =====
`default_nettype none

module bsme_front (
  bsme_in_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output bsme_pkg::instr_t push_data_o
);

  bsme_pkg::op_e op;

  always_comb begin
    case (in_i.opcode)
      bsme_pkg::OPC_HALT: op = bsme_pkg::OP_HALT;
      bsme_pkg::OPC_PUSH: op = bsme_pkg::OP_PUSH;
      bsme_pkg::OPC_POP:  op = bsme_pkg::OP_POP;
      bsme_pkg::OPC_ADD:  op = bsme_pkg::OP_ADD;
      bsme_pkg::OPC_SUM:  op = bsme_pkg::OP_SUM;
      bsme_pkg::OPC_PRIM: begin
        op = (in_i.operand == bsme_pkg::PRIM_PRINT) ? bsme_pkg::OP_PRINT
                                                    : bsme_pkg::OP_BAD_PRIM;
      end
      default: op = bsme_pkg::OP_BAD_OPC;
    endcase
  end

  assign push_valid_o        = in_i.valid;
  assign in_i.ready          = push_ready_i;
  assign push_data_o.op      = op;
  assign push_data_o.operand = in_i.operand;

endmodule

`default_nettype wire

// ===== rtl/bsme_queue.sv =====
`default_nettype none

module bsme_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  bsme_pkg::instr_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output bsme_pkg::instr_t pop_data_o
);

  localparam int Depth = bsme_pkg::QDEPTH;
  localparam int IW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = $clog2(Depth + 1);

  bsme_pkg::instr_t mem_q [Depth];
  logic [IW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [IW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IW'(Depth - 1)) ? '0 : wr_ptr_q + IW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IW'(Depth - 1)) ? '0 : rd_ptr_q + IW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsme_back.sv =====
`default_nettype none

module bsme_back #(
  parameter int STACK_DEPTH = 2048
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  bsme_pkg::instr_t pop_data_i,
  bsme_out_if.source       out_o
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = (SPW > 8) ? SPW : 8;
  localparam int DW  = bsme_pkg::DEPTH_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TOP  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [SPW-1:0]   sp_q, sp_d;
  logic             stop_q, stop_d;
  logic             out_valid_q, out_valid_d;
  bsme_pkg::res_t   res_q, res_d;
  bsme_pkg::instr_t cur_q, cur_d;
  logic [7:0]       acc_q, acc_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [AW-1:0]    tgt_q, tgt_d;
  logic [AW-1:0]    walk_q, walk_d;
  logic [SPW-1:0]   nsp_q, nsp_d;

  logic [7:0]       mem [STACK_DEPTH];
  logic [7:0]       rd_data_q;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [7:0]       wr_data;

  logic             out_free, res_valid;
  bsme_pkg::status_e res_status;
  logic             res_printed;
  logic [7:0]       res_pval;
  logic [7:0]       top;
  logic [CW-1:0]    sp_m1;
  logic             full, lt2;

  assign out_free = !out_valid_q || out_o.ready;
  assign top      = rd_data_q;
  assign sp_m1    = CW'(sp_q) - CW'(1);
  assign full     = (sp_q == SPW'(STACK_DEPTH));
  assign lt2      = (sp_q < SPW'(2));

  always_comb begin
    state_d     = state_q;
    sp_d        = sp_q;
    stop_d      = stop_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    walk_d      = walk_q;
    nsp_d       = nsp_q;
    rd_en       = 1'b0;
    rd_addr     = walk_q;
    wr_en       = 1'b0;
    wr_addr     = AW'(sp_q);
    wr_data     = pop_data_i.operand;
    pop_ready_o = 1'b0;
    res_valid   = 1'b0;
    res_status  = bsme_pkg::ST_OK;
    res_printed = 1'b0;
    res_pval    = '0;

    case (state_q)
      S_IDLE: begin
        if (pop_valid_i && out_free) begin
          pop_ready_o = 1'b1;
          cur_d       = pop_data_i;
          if (stop_q) begin
            res_valid  = 1'b1;
            res_status = bsme_pkg::ST_HALTED;
          end else begin
            case (pop_data_i.op)
              bsme_pkg::OP_HALT: begin
                res_valid  = 1'b1;
                res_status = bsme_pkg::ST_HALTED;
                stop_d     = 1'b1;
              end
              bsme_pkg::OP_PUSH: begin
                res_valid = 1'b1;
                if (full) begin
                  res_status = bsme_pkg::ST_OVERFLOW;
                  stop_d     = 1'b1;
                end else begin
                  wr_en = 1'b1;
                  sp_d  = sp_q + SPW'(1);
                end
              end
              bsme_pkg::OP_POP: begin
                res_valid = 1'b1;
                if (sp_q == '0) begin
                  res_status = bsme_pkg::ST_UNDERFLOW;
                  stop_d     = 1'b1;
                end else begin
                  sp_d = sp_q - SPW'(1);
                end
              end
              bsme_pkg::OP_ADD: begin
                if (lt2) begin
                  res_valid  = 1'b1;
                  res_status = bsme_pkg::ST_UNDERFLOW;
                  stop_d     = 1'b1;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(sp_m1);
                  state_d = S_TOP;
                end
              end
              bsme_pkg::OP_SUM, bsme_pkg::OP_PRINT: begin
                if (sp_q == '0) begin
                  res_valid  = 1'b1;
                  res_status = bsme_pkg::ST_UNDERFLOW;
                  stop_d     = 1'b1;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(sp_m1);
                  state_d = S_TOP;
                end
              end
              bsme_pkg::OP_BAD_PRIM: begin
                res_valid  = 1'b1;
                res_status = bsme_pkg::ST_BAD_PRIM;
                stop_d     = 1'b1;
              end
              default: begin
                res_valid  = 1'b1;
                res_status = bsme_pkg::ST_BAD_OPC;
                stop_d     = 1'b1;
              end
            endcase
          end
        end
      end

      S_TOP: begin
        case (cur_q.op)
          bsme_pkg::OP_ADD: begin
            acc_d   = top;
            cnt_d   = 8'd1;
            tgt_d   = AW'(sp_q - SPW'(2));
            nsp_d   = sp_q - SPW'(1);
            walk_d  = AW'(sp_q - SPW'(2));
            rd_en   = 1'b1;
            rd_addr = AW'(sp_q - SPW'(2));
            state_d = S_WALK;
          end
          bsme_pkg::OP_PRINT: begin
            if (top != 8'd1 || lt2) begin
              if (out_free) begin
                res_valid  = 1'b1;
                res_status = (top != 8'd1) ? bsme_pkg::ST_BAD_ARITY
                                           : bsme_pkg::ST_UNDERFLOW;
                stop_d     = 1'b1;
                state_d    = S_IDLE;
              end
            end else begin
              acc_d   = '0;
              cnt_d   = 8'd1;
              tgt_d   = AW'(sp_q - SPW'(2));
              nsp_d   = sp_q - SPW'(1);
              walk_d  = AW'(sp_q - SPW'(2));
              rd_en   = 1'b1;
              rd_addr = AW'(sp_q - SPW'(2));
              state_d = S_WALK;
            end
          end
          default: begin
            if (sp_m1 < CW'(top)) begin
              if (out_free) begin
                res_valid  = 1'b1;
                res_status = bsme_pkg::ST_UNDERFLOW;
                stop_d     = 1'b1;
                state_d    = S_IDLE;
              end
            end else if (top == '0) begin
              // empty sum: length slot becomes a zero total
              if (out_free) begin
                wr_en     = 1'b1;
                wr_addr   = AW'(sp_m1);
                wr_data   = '0;
                res_valid = 1'b1;
                state_d   = S_IDLE;
              end
            end else begin
              acc_d   = '0;
              cnt_d   = top;
              tgt_d   = AW'(sp_m1 - CW'(top));
              nsp_d   = SPW'(CW'(sp_q) - CW'(top));
              walk_d  = AW'(sp_q - SPW'(2));
              rd_en   = 1'b1;
              rd_addr = AW'(sp_q - SPW'(2));
              state_d = S_WALK;
            end
          end
        endcase
      end

      S_WALK: begin
        if (cnt_q > 8'd1) begin
          acc_d   = acc_q + rd_data_q;
          cnt_d   = cnt_q - 8'd1;
          walk_d  = walk_q - AW'(1);
          rd_en   = 1'b1;
          rd_addr = walk_q - AW'(1);
        end else if (out_free) begin
          wr_en     = 1'b1;
          wr_addr   = tgt_q;
          wr_data   = (cur_q.op == bsme_pkg::OP_PRINT) ? 8'd0 : acc_q + rd_data_q;
          sp_d      = nsp_q;
          res_valid = 1'b1;
          if (cur_q.op == bsme_pkg::OP_PRINT) begin
            res_printed = 1'b1;
            res_pval    = rd_data_q;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    res_d.status      = res_status;
    res_d.printed     = res_printed;
    res_d.print_value = res_pval;
    res_d.stack_depth = DW'(sp_d);
    out_valid_d       = res_valid ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    tgt_q  <= tgt_d;
    walk_q <= walk_d;
    nsp_q  <= nsp_d;
    if (res_valid) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = res_q.status;
  assign out_o.printed     = res_q.printed;
  assign out_o.print_value = res_q.print_value;
  assign out_o.stack_depth = res_q.stack_depth;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack size");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("stopped flag cleared");

  a_no_write_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |-> !wr_en && (sp_d == sp_q))
    else $error("stack changed while stopped");

  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (cnt_q != '0))
    else $error("walk with zero count");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !pop_ready_o)
    else $error("instruction taken while busy");
`endif

endmodule

`default_nettype wire
